// File: rtl/mmn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmn_pkg
// Shared widths, codes and types of the min-max normalizer.
// ----------------------------------------------------------------------------
package mmn_pkg;

   // sample format, signed fixed point
   localparam int SAMPLE_WIDTH = 24;
   localparam int FRAC_BITS    = 16;

   // result and weight are unsigned with one integer bit
   localparam int VALUE_W   = FRAC_BITS + 1;
   localparam int WEIGHT_W  = FRAC_BITS + 1;
   localparam int NUM_W     = SAMPLE_WIDTH + WEIGHT_W;
   localparam int DIV_STEPS = VALUE_W;

   localparam logic [VALUE_W-1:0]  ONE_VALUE    = {1'b1, {FRAC_BITS{1'b0}}};
   localparam logic [WEIGHT_W-1:0] WEIGHT_RESET = {1'b1, {FRAC_BITS{1'b0}}};

   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MAXV = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
   localparam logic signed [SAMPLE_WIDTH-1:0] SAMPLE_MINV = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};

   // queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // item kinds
   localparam logic [1:0] KIND_CLEAR   = 2'd0;
   localparam logic [1:0] KIND_OBSERVE = 2'd1;
   localparam logic [1:0] KIND_SCALE   = 2'd2;

   // one scale job, classified by the front
   typedef struct packed {
      logic                    degenerate;
      logic                    below;
      logic [SAMPLE_WIDTH-1:0] diff;
      logic [SAMPLE_WIDTH-1:0] range;
   } mmn_entry_type;

   // queue status seen by both sides
   typedef struct packed {
      logic empty;
      logic full;
   } mmn_qstat_type;

   // one result beat
   typedef struct packed {
      logic [VALUE_W-1:0] value;
      logic               clamped;
      logic               degenerate;
   } mmn_result_type;

endpackage
`default_nettype wire

// File: rtl/mmn_fifo.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmn_fifo
// Short queue of scale jobs between the front and the back.
// ----------------------------------------------------------------------------
module mmn_fifo
   import mmn_pkg::*;
(
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          push,
   input  wire mmn_entry_type push_data,
   input  wire logic          pop,
   output mmn_entry_type      pop_data,
   output mmn_qstat_type      stat
);

   mmn_entry_type           slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]       cnt_ff, cnt_in;
   logic                    do_push, do_pop;

   // status and guarded handshakes
   always_comb begin
      stat.empty = (cnt_ff == '0);
      stat.full  = (cnt_ff == QCNT_W'(QUEUE_DEPTH));
      do_push    = push && !stat.full;
      do_pop     = pop && !stat.empty;
      pop_data   = slot_ff[rd_ptr_ff];
   end

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (!do_push && do_pop) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // slot storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mmn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmn_front
// Accepts request beats, keeps the running extremes and classifies scale jobs.
// ----------------------------------------------------------------------------
module mmn_front
   import mmn_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  wire mmn_qstat_type                  qstat,
   output logic                                push,
   output mmn_entry_type                       push_data
);

   logic signed [SAMPLE_WIDTH-1:0] run_min_ff, run_min_in;
   logic signed [SAMPLE_WIDTH-1:0] run_max_ff, run_max_in;
   logic                           seen_ff, seen_in;
   logic signed [SAMPLE_WIDTH:0]   diff_w;
   logic signed [SAMPLE_WIDTH:0]   range_w;
   logic                           accept;

   assign req_ready = !qstat.full;
   assign accept    = req_valid && req_ready;

   // classify a scale beat against the current extremes
   always_comb begin
      diff_w  = {req_sample[SAMPLE_WIDTH-1], req_sample}
              - {run_min_ff[SAMPLE_WIDTH-1], run_min_ff};
      range_w = {run_max_ff[SAMPLE_WIDTH-1], run_max_ff}
              - {run_min_ff[SAMPLE_WIDTH-1], run_min_ff};
      push_data.degenerate = !seen_ff || (run_max_ff <= run_min_ff);
      push_data.below      = diff_w[SAMPLE_WIDTH];
      push_data.diff       = diff_w[SAMPLE_WIDTH-1:0];
      push_data.range      = range_w[SAMPLE_WIDTH-1:0];
      push                 = accept && (req_kind == KIND_SCALE);
   end

   // extremes update
   always_comb begin
      run_min_in = run_min_ff;
      run_max_in = run_max_ff;
      seen_in    = seen_ff;
      if (accept) begin
         unique case (req_kind)
            KIND_CLEAR: begin
               run_min_in = SAMPLE_MAXV;
               run_max_in = SAMPLE_MINV;
               seen_in    = 1'b0;
            end
            KIND_OBSERVE: begin
               if (!seen_ff || (req_sample < run_min_ff)) begin
                  run_min_in = req_sample;
               end
               if (!seen_ff || (req_sample > run_max_ff)) begin
                  run_max_in = req_sample;
               end
               seen_in = 1'b1;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_min_ff <= SAMPLE_MAXV;
         run_max_ff <= SAMPLE_MINV;
         seen_ff    <= 1'b0;
      end else begin
         run_min_ff <= run_min_in;
         run_max_ff <= run_max_in;
         seen_ff    <= seen_in;
      end
   end

endmodule
`default_nettype wire

// File: rtl/mmn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mmn_back
// Scales queued jobs: one multiply, a range check, a serial restoring divide.
// ----------------------------------------------------------------------------
module mmn_back
   import mmn_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                csr_wen,
   input  wire logic [WEIGHT_W-1:0] csr_wdata,
   input  wire mmn_qstat_type       qstat,
   input  wire mmn_entry_type       pop_data,
   output logic                     pop,
   output logic                     rsp_valid,
   input  wire logic                rsp_ready,
   output logic [VALUE_W-1:0]       rsp_value,
   output logic                     rsp_clamped,
   output logic                     rsp_degenerate
);

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_CHK  = 3'd2;
   localparam logic [2:0] ST_DIV  = 3'd3;
   localparam logic [2:0] ST_FIN  = 3'd4;

   localparam int CNT_W = $clog2(DIV_STEPS);

   logic [2:0]              state_ff, state_in;
   logic [WEIGHT_W-1:0]     weight_ff, weight_in;
   mmn_entry_type           ent_ff, ent_in;
   logic [NUM_W-1:0]        num_ff, num_in;
   logic [SAMPLE_WIDTH-1:0] rem_ff, rem_in;
   logic [DIV_STEPS-1:0]    nlo_ff, nlo_in;
   logic [VALUE_W-1:0]      quo_ff, quo_in;
   logic [CNT_W-1:0]        cnt_ff, cnt_in;
   mmn_result_type          res_ff, res_in;
   mmn_result_type          out_ff, out_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SAMPLE_WIDTH:0]   trial;
   logic [SAMPLE_WIDTH:0]   trial_sub;
   logic                    trial_ge;
   logic                    load_out;

   // weight register
   assign weight_in = csr_wen ? csr_wdata : weight_ff;

   // one restoring divide step
   always_comb begin
      trial     = {rem_ff, nlo_ff[DIV_STEPS-1]};
      trial_ge  = (trial >= {1'b0, ent_ff.range});
      trial_sub = trial - {1'b0, ent_ff.range};
   end

   // sequencer
   always_comb begin
      state_in = state_ff;
      ent_in   = ent_ff;
      num_in   = num_ff;
      rem_in   = rem_ff;
      nlo_in   = nlo_ff;
      quo_in   = quo_ff;
      cnt_in   = cnt_ff;
      res_in   = res_ff;
      pop      = 1'b0;
      load_out = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (!qstat.empty) begin
               pop    = 1'b1;
               ent_in = pop_data;
               res_in = '0;
               if (pop_data.degenerate) begin
                  res_in.degenerate = 1'b1;
                  state_in          = ST_FIN;
               end else if (pop_data.below) begin
                  res_in.clamped = (weight_ff != '0);
                  state_in       = ST_FIN;
               end else begin
                  state_in = ST_MUL;
               end
            end
         end
         ST_MUL: begin
            num_in   = ent_ff.diff * weight_ff;
            state_in = ST_CHK;
         end
         ST_CHK: begin
            if (num_ff > {1'b0, ent_ff.range, {FRAC_BITS{1'b0}}}) begin
               res_in.value   = ONE_VALUE;
               res_in.clamped = 1'b1;
               state_in       = ST_FIN;
            end else begin
               rem_in   = num_ff[NUM_W-1 -: SAMPLE_WIDTH];
               nlo_in   = num_ff[DIV_STEPS-1:0];
               quo_in   = '0;
               cnt_in   = CNT_W'(DIV_STEPS - 1);
               state_in = ST_DIV;
            end
         end
         ST_DIV: begin
            rem_in = trial_ge ? trial_sub[SAMPLE_WIDTH-1:0] : trial[SAMPLE_WIDTH-1:0];
            nlo_in = {nlo_ff[DIV_STEPS-2:0], 1'b0};
            quo_in = {quo_ff[VALUE_W-2:0], trial_ge};
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               res_in.value = {quo_ff[VALUE_W-2:0], trial_ge};
               state_in     = ST_FIN;
            end
         end
         ST_FIN: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // output register
   always_comb begin
      out_in       = load_out ? res_ff : out_ff;
      rsp_valid_in = load_out ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         weight_ff    <= WEIGHT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         weight_ff    <= weight_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      ent_ff <= ent_in;
      num_ff <= num_in;
      rem_ff <= rem_in;
      nlo_ff <= nlo_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
      res_ff <= res_in;
      out_ff <= out_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_value      = out_ff.value;
   assign rsp_clamped    = out_ff.clamped;
   assign rsp_degenerate = out_ff.degenerate;

endmodule
`default_nettype wire

// File: rtl/min_max_normalizer_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// min_max_normalizer_top
// Two-pass min-max normalizer for one axis of Q8.16 samples.
// ----------------------------------------------------------------------------
// Clear and observe beats are taken one per cycle unless the queue is full
// and update the running extremes at once; a scale beat is classified
// against the extremes as they stand when it is accepted and waits in a
// two-entry queue for the back end. A scale job whose sample lies in range
// goes through dequeue, multiply by the weight, range check, 17 steps of a
// serial restoring divider and hand-off to the output register; a degenerate
// or below-minimum job goes from dequeue to hand-off. The divider sets the
// sustained rate for scale beats; the request side stalls only when the
// queue is full. Write the weight only while no scale beat is in flight.
// ----------------------------------------------------------------------------
module min_max_normalizer_top
   import mmn_pkg::*;
(
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [1:0]                     req_kind,
   input  wire logic signed [SAMPLE_WIDTH-1:0] req_sample,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output logic [VALUE_W-1:0]                  rsp_value,
   output logic                                rsp_clamped,
   output logic                                rsp_degenerate,
   input  wire logic                           csr_wen,
   input  wire logic [WEIGHT_W-1:0]            csr_wdata
);

   mmn_qstat_type qstat;
   mmn_entry_type push_data;
   mmn_entry_type pop_data;
   logic          push;
   logic          pop;

   // front end: extremes and classification
   mmn_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_kind   (req_kind),
      .req_sample (req_sample),
      .qstat      (qstat),
      .push       (push),
      .push_data  (push_data)
   );

   // job queue
   mmn_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .stat      (qstat)
   );

   // back end: multiply and divide
   mmn_back u_back (
      .clock          (clock),
      .reset          (reset),
      .csr_wen        (csr_wen),
      .csr_wdata      (csr_wdata),
      .qstat          (qstat),
      .pop_data       (pop_data),
      .pop            (pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_clamped    (rsp_clamped),
      .rsp_degenerate (rsp_degenerate)
   );

   // degenerate beats carry a zero value and no clamp
   a_degenerate_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_degenerate) |-> (rsp_value == '0 && !rsp_clamped))
      else $error("degenerate beat with nonzero value or clamp");

   // result never exceeds full scale
   a_value_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_value <= ONE_VALUE))
      else $error("result above full scale");

   // front never pushes into a full queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      qstat.full |-> !push)
      else $error("push into full queue");

   // back never pops an empty queue
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      qstat.empty |-> !pop)
      else $error("pop from empty queue");

endmodule
`default_nettype wire
